// ----- rtl/core/bist_pkg.sv -----
package bist_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 31;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC,
        S_MOVE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic exec;
        logic move;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic need_move;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/bounded_integer_set_table_unit.sv -----
// Set of up to 64 distinct 31-bit natural numbers held in an unordered table.
// The slave channel takes one operation per transfer: tuser carries the kind
// (query, insert or delete) and tdata carries the value. The master channel
// returns one result per operation with status, membership, the counts of
// stored values below and above the value, and the set size afterwards.
// Each operation scans the stored entries through the table RAM, one read
// per cycle; a delete that removes an entry then moves the last entry into
// the freed slot. The controller steps through scan, drain, exec, an optional
// move and finish, then returns to the idle state, where alone a transfer is
// taken, so a new operation is accepted only after the previous one has left
// its finish state.
// A finished result sits in the output register until the receiver takes it,
// and the next operation is accepted and scanned meanwhile; it only waits at
// its end if the previous result is still held. Reset empties the set and
// drops any pending result; the table contents need no clearing.
module bounded_integer_set_table_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // value[30:0], zero [31]
    input  logic [bist_pkg::S_DATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [bist_pkg::KIND_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], is_member[2], count_below[9:3], count_above[16:10], set_size[23:17]
    output logic [bist_pkg::M_DATA_W-1:0] m_tdata
);
    import bist_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bist_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/bist_ram.sv -----
module bist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bist_datapath.sv -----
module bist_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bist_pkg::dp_cmd_t                 cmd,
    output bist_pkg::dp_stat_t                stat,
    input  logic [bist_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [bist_pkg::KIND_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bist_pkg::M_DATA_W-1:0]     m_tdata
);
    import bist_pkg::*;

    logic [KIND_W-1:0]   kind_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    size_reg, size_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic                rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]    below_reg, below_next;
    logic [CNT_W-1:0]    above_reg, above_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   hit_reg, hit_next;
    status_t             status_reg, status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_data_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr, last_addr;
    logic [VALUE_W-1:0]  ram_wdata, ram_rdata;
    logic                insert_ok;

    bist_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign last_addr = ADDR_W'(size_reg - CNT_W'(1));
    assign insert_ok = (kind_reg == KIND_INSERT) && !found_reg
                       && (size_reg < CNT_W'(CAPACITY));

    always_comb begin
        ram_raddr = cmd.exec ? last_addr : idx_reg[ADDR_W-1:0];
        ram_we    = (cmd.exec && insert_ok) || cmd.move;
        ram_waddr = cmd.move ? hit_reg : size_reg[ADDR_W-1:0];
        ram_wdata = cmd.move ? ram_rdata : value_reg;
    end

    always_comb begin
        idx_next     = idx_reg;
        rd_pend_next = cmd.scan;
        below_next   = below_reg;
        above_next   = above_reg;
        found_next   = found_reg;
        hit_next     = hit_reg;
        size_next    = size_reg;
        status_next  = status_reg;
        if (cmd.start) begin
            idx_next   = '0;
            below_next = '0;
            above_next = '0;
            found_next = 1'b0;
        end else begin
            if (cmd.scan) begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (rd_pend_reg) begin
                if (ram_rdata < value_reg) begin
                    below_next = below_reg + CNT_W'(1);
                end else if (ram_rdata > value_reg) begin
                    above_next = above_reg + CNT_W'(1);
                end else if (!found_reg) begin
                    found_next = 1'b1;
                    hit_next   = rd_addr_reg;
                end
            end
        end
        if (cmd.exec) begin
            if (kind_reg == KIND_INSERT) begin
                if (found_reg) begin
                    status_next = ST_PRESENT;
                end else if (!insert_ok) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_OK;
                    size_next   = size_reg + CNT_W'(1);
                end
            end else begin
                status_next = found_reg ? ST_OK : ST_ABSENT;
            end
        end
        if (cmd.move) begin
            size_next = size_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            size_reg     <= size_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg  <= s_tuser;
            value_reg <= s_tdata[VALUE_W-1:0];
        end
        rd_addr_reg <= idx_reg[ADDR_W-1:0];
        idx_reg     <= idx_next;
        below_reg   <= below_next;
        above_reg   <= above_next;
        found_reg   <= found_next;
        hit_reg     <= hit_next;
        status_reg  <= status_next;
        if (cmd.finish) begin
            m_data_reg <= {size_reg, above_reg, below_reg, found_reg, status_reg};
        end
    end

    assign stat.scan_done = (idx_reg == size_reg);
    assign stat.need_move = (kind_reg == KIND_DELETE) && found_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/core/bist_ctrl.sv -----
module bist_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bist_pkg::dp_stat_t stat,
    output bist_pkg::dp_cmd_t  cmd
);
    import bist_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = stat.need_move ? S_MOVE : S_FINISH;
            end
            S_MOVE: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_SCAN: begin
                cmd.scan = !stat.scan_done;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
            end
            S_MOVE: begin
                cmd.move = 1'b1;
            end
            S_FINISH: begin
                cmd.finish = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/bist_checker.sv -----
module bist_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bist_pkg::S_DATA_W-1:0] s_tdata,
    input logic [bist_pkg::KIND_W-1:0]   s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bist_pkg::M_DATA_W-1:0] m_tdata
);
    import bist_pkg::*;

    // A held result must not change while the receiver stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Full and absent reports never claim membership; present always does.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[1:0] == ST_FULL) || (m_tdata[1:0] == ST_ABSENT))
                     == !m_tdata[2] || (m_tdata[1:0] == ST_OK))
        else $error("status and membership disagree");

    // Full store is reported only at capacity, and the size never exceeds it.
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:17] <= CNT_W'(CAPACITY))
                     && ((m_tdata[1:0] != ST_FULL) || (m_tdata[23:17] == CNT_W'(CAPACITY))))
        else $error("size out of range");

    // The counts below and above the value together never exceed the capacity.
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[9:3]} + {1'b0, m_tdata[16:10]}
                      <= {1'b0, CNT_W'(CAPACITY)}))
        else $error("counts exceed capacity");

endmodule

bind bounded_integer_set_table_unit bist_checker u_bist_checker (.*);

// ----- verif/tb_bounded_integer_set_table_unit.sv -----
`timescale 1ns / 100ps

module tb_bounded_integer_set_table_unit;
    import bist_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 100;
    localparam int POOL_SIZE    = 96;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED, PHASE_NOISE} phase_t;

    typedef struct {
        status_t          status;
        bit               member;
        bit [CNT_W-1:0]   below;
        bit [CNT_W-1:0]   above;
        bit [CNT_W-1:0]   size;
    } set_reply_t;

    class set_table_scoreboard;
        bit [VALUE_W-1:0] members[$];
        set_reply_t       awaited_replies[$];
        int               mismatches;
        int               replies_checked;
        int               ops_noted;
        int               status_seen[4];
        int               peak_size;

        function void apply_op(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
            set_reply_t r;
            int         hit;
            int         below;
            int         above;
            hit = -1;
            below = 0;
            above = 0;
            foreach (members[i]) begin
                if (members[i] < value) begin
                    below++;
                end else if (members[i] > value) begin
                    above++;
                end else if (hit < 0) begin
                    hit = i;
                end
            end
            r.member = (hit >= 0);
            if (kind == KIND_INSERT) begin
                if (hit >= 0) begin
                    r.status = ST_PRESENT;
                end else if (members.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    members.push_back(value);
                    r.status = ST_OK;
                end
            end else if (kind == KIND_DELETE) begin
                if (hit < 0) begin
                    r.status = ST_ABSENT;
                end else begin
                    members.delete(hit);
                    r.status = ST_OK;
                end
            end else begin
                r.status = (hit >= 0) ? ST_OK : ST_ABSENT;
            end
            r.below = below[CNT_W-1:0];
            r.above = above[CNT_W-1:0];
            r.size  = CNT_W'(members.size());
            awaited_replies.push_back(r);
            ops_noted++;
            status_seen[r.status]++;
            if (members.size() > peak_size) begin
                peak_size = members.size();
            end
        endfunction

        function void check_reply(logic [M_DATA_W-1:0] data);
            set_reply_t want;
            bit         bad;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result transfer with nothing outstanding, data %h",
                             $realtime, data);
                end
                return;
            end
            want = awaited_replies.pop_front();
            replies_checked++;
            bad = (data[1:0] !== want.status) || (data[2] !== want.member) ||
                  (data[9:3] !== want.below) || (data[16:10] !== want.above) ||
                  (data[23:17] !== want.size);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result %0d expected st=%0d mem=%0d lo=%0d hi=%0d sz=%0d",
                             $realtime, replies_checked, want.status, want.member,
                             want.below, want.above, want.size);
                    $display("%0t: result %0d actual   st=%0d mem=%0d lo=%0d hi=%0d sz=%0d",
                             $realtime, replies_checked, data[1:0], data[2], data[9:3],
                             data[16:10], data[23:17]);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    set_table_scoreboard   sb;
    logic [VALUE_W-1:0]    value_pool[POOL_SIZE];
    bit                    no_idle;
    bit                    pressure_done;
    int                    items_sent;
    int                    cycle_count;

    bounded_integer_set_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                sb.check_reply(m_tdata);
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
                sb.apply_op(s_tuser, s_tdata[VALUE_W-1:0]);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(bit any_value);
        logic [31:0] raw;
        raw = $urandom();
        if (any_value || $urandom_range(0, 99) < 15) begin
            return raw[VALUE_W-1:0];
        end
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PHASE_GROW: begin
                if (r < 60) return KIND_INSERT;
                if (r < 78) return KIND_QUERY;
                if (r < 95) return KIND_DELETE;
                return KIND_SPARE;
            end
            PHASE_SHRINK: begin
                if (r < 55) return KIND_DELETE;
                if (r < 70) return KIND_INSERT;
                if (r < 95) return KIND_QUERY;
                return KIND_SPARE;
            end
            default: begin
                if (r < 33) return KIND_INSERT;
                if (r < 66) return KIND_QUERY;
                if (r < 95) return KIND_DELETE;
                return KIND_SPARE;
            end
        endcase
    endfunction

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {1'b0, value};
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
        items_sent++;
    endtask

    // Receiver: random stalls, idle-free stretches, and one long hold-off that
    // backs the block up while the sender keeps offering operations.
    initial begin
        int stall_left;
        int hold_left;
        m_tready = 1'b0;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (!pressure_done && sb.replies_checked >= 300) begin
                pressure_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (no_idle) begin
                stall_left = 0;
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if ($urandom_range(0, 99) < 70) begin
                m_tready = 1'b1;
            end else begin
                stall_left = pick_gap();
                m_tready = 1'b0;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, sb.awaited_replies.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        phase_t      phase;
        int          seg_len;
        int          extra;
        logic [31:0] raw;
        sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_QUERY;
        no_idle  = 1'b0;
        pressure_done = 1'b0;
        items_sent = 0;
        cycle_count = 0;
        foreach (value_pool[i]) begin
            raw = $urandom();
            value_pool[i] = raw[VALUE_W-1:0];
        end
        value_pool[0] = '0;
        value_pool[1] = VALUE_MAX;
        value_pool[2] = 31'd1;
        value_pool[3] = VALUE_MAX - 31'd1;
        value_pool[4] = 31'h4000_0000;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty set, extremes, duplicates, absent deletes, spare kind,
        // deletes at the front, middle and end of the table.
        send_op(KIND_QUERY,  '0);
        send_op(KIND_DELETE, 31'd5);
        send_op(KIND_INSERT, '0);
        send_op(KIND_INSERT, VALUE_MAX);
        send_op(KIND_INSERT, VALUE_MAX);
        send_op(KIND_QUERY,  VALUE_MAX);
        send_op(KIND_QUERY,  '0);
        send_op(KIND_SPARE,  31'd1000);
        send_op(KIND_INSERT, 31'd1000);
        send_op(KIND_QUERY,  31'd999);
        send_op(KIND_DELETE, 31'd1000);
        send_op(KIND_INSERT, 31'd1000);
        send_op(KIND_INSERT, 31'd7);
        send_op(KIND_DELETE, VALUE_MAX);
        send_op(KIND_QUERY,  VALUE_MAX);
        send_op(KIND_DELETE, '0);
        send_op(KIND_DELETE, '0);
        send_op(KIND_INSERT, 31'h5555_5555);
        send_op(KIND_INSERT, 31'h2AAA_AAAA);
        send_op(KIND_SPARE,  31'h4000_0000);
        send_op(KIND_QUERY,  31'h7FFF_FFFE);

        // Fill the table to capacity, then push past it.
        while (sb.members.size() < CAPACITY) begin
            send_op(($urandom_range(0, 4) == 0) ? KIND_QUERY : KIND_INSERT, pick_value(1'b0));
        end
        for (extra = 0; extra < 8; extra++) begin
            send_op(KIND_INSERT, pick_value(extra[0]));
        end

        while (items_sent < RANDOM_ITEMS) begin
            if (sb.members.size() > 56) begin
                phase = ($urandom_range(0, 2) == 0) ? PHASE_GROW : PHASE_SHRINK;
            end else if (sb.members.size() < 8) begin
                phase = ($urandom_range(0, 3) == 0) ? PHASE_MIXED : PHASE_GROW;
            end else begin
                phase = phase_t'($urandom_range(0, 3));
            end
            seg_len = $urandom_range(20, 100);
            no_idle = ($urandom_range(0, 3) == 0);
            raw = $urandom();
            value_pool[$urandom_range(5, POOL_SIZE - 1)] = raw[VALUE_W-1:0];
            repeat (seg_len) begin
                if (phase == PHASE_NOISE) begin
                    raw = $urandom();
                    send_op(raw[31:30], pick_value(1'b1));
                end else begin
                    send_op(pick_kind(phase), pick_value(1'b0));
                end
            end
        end
        s_tvalid = 1'b0;
        no_idle = 1'b0;

        while (sb.awaited_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d operations, checked %0d results; largest set held %0d values.",
                 sb.ops_noted, sb.replies_checked, sb.peak_size);
        $display("Status mix ok/present/absent/full: %0d/%0d/%0d/%0d, mismatches %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_PRESENT],
                 sb.status_seen[ST_ABSENT], sb.status_seen[ST_FULL], sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
